// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the buffer pool frame table.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge.
`define BP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bplru_pkg.sv =====
// Shared types and constants of the buffer pool frame table.
// No dependencies; imported by every RTL module of the block.
package bplru_pkg;

  localparam int NUM_FRAMES_DEF = 16;

  localparam int CMD_W  = 3;
  localparam int FILE_W = 16;
  localparam int PAGE_W = 24;
  localparam int PB_W   = 17;
  localparam int HB_W   = 16;
  localparam int OFF_W  = 41;
  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [PB_W-1:0] PAGE_BYTES_RST   = 17'd4096;
  localparam logic [HB_W-1:0] HEADER_BYTES_RST = 16'd0;

  // Register index taken from paddr[2].
  localparam logic REG_PAGE_BYTES   = 1'b0;
  localparam logic REG_HEADER_BYTES = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET, CMD_ALLOC, CMD_DIRTY, CMD_UNPIN,
    CMD_FLUSH_PAGE, CMD_FLUSH_FILE, CMD_CLEAR, CMD_NOP
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FINAL, KIND_WB, KIND_FILL
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK, STS_NO_FREE, STS_RESIDENT, STS_NOT_RESIDENT, STS_NOT_PINNED
  } status_t;

  // Operations on a list row: push at head, move key to head (or push when
  // absent), remove key, pop head.
  typedef enum logic [2:0] {
    LOP_HOLD, LOP_PUSH, LOP_MOVE, LOP_REMOVE, LOP_POP
  } list_op_t;

  typedef struct packed {
    logic head_vld;
    logic tail_vld;
    logic victim_found;
  } list_stat_t;

endpackage

// ===== hw/rtl/bplru_cell.sv =====
// One slot of a frame list: holds a frame index and a valid bit and
// trades them with its neighbors. Depends on bplru_pkg.
module bplru_cell #(
  parameter int FW       = 4,
  parameter bit INIT_VLD = 1'b0,
  parameter int INIT_ID  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bplru_pkg::list_op_t  op,
  input  logic [FW-1:0]        key,
  input  logic                 prv_vld,
  input  logic [FW-1:0]        prv_id,
  input  logic                 nxt_vld,
  input  logic [FW-1:0]        nxt_id,
  input  logic                 found_in,
  output logic                 found_out,
  input  logic                 unpinned,
  input  logic                 later_in,
  input  logic [FW-1:0]        later_id_in,
  output logic                 later_out,
  output logic [FW-1:0]        later_id_out,
  output logic                 vld,
  output logic [FW-1:0]        id
);
  import bplru_pkg::*;

  logic          vld_r;
  logic [FW-1:0] id_r;
  logic          own_match;
  logic          take_prv;
  logic          take_nxt;

  assign own_match    = vld_r && (id_r == key);
  assign found_out    = found_in || own_match;
  assign later_out    = later_in || (vld_r && unpinned);
  assign later_id_out = later_in ? later_id_in : id_r;
  assign vld          = vld_r;
  assign id           = id_r;

  always_comb begin
    take_prv = 1'b0;
    take_nxt = 1'b0;
    case (op)
      LOP_PUSH:   take_prv = 1'b1;
      LOP_MOVE:   take_prv = !found_in;
      LOP_REMOVE: take_nxt = found_out;
      LOP_POP:    take_nxt = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= INIT_VLD;
      id_r  <= FW'(INIT_ID);
    end else if (take_prv) begin
      vld_r <= prv_vld;
      id_r  <= prv_id;
    end else if (take_nxt) begin
      vld_r <= nxt_vld;
      id_r  <= nxt_id;
    end
  end

endmodule

// ===== hw/rtl/bplru_list.sv =====
// Row of bplru_cell slots forming an ordered frame list, head at slot 0.
// Depends on bplru_pkg and bplru_cell.
module bplru_list #(
  parameter int N         = 16,
  parameter int FW        = 4,
  parameter bit INIT_FULL = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bplru_pkg::list_op_t    op,
  input  logic [FW-1:0]          key,
  input  logic [N-1:0]           pinned,
  output bplru_pkg::list_stat_t  stat,
  output logic [FW-1:0]          head_id,
  output logic [FW-1:0]          victim_id,
  output logic [N-1:0]           vld_vec
);
  import bplru_pkg::*;

  logic [FW-1:0]     id_a  [N];
  logic [N:0]        found;
  logic [N:0]        later;
  logic [FW-1:0]     lid   [N+1];
  logic [2**FW-1:0]  pin_pad;

  always_comb begin
    pin_pad        = '0;
    pin_pad[N-1:0] = pinned;
  end

  assign found[0] = 1'b0;
  assign later[N] = 1'b0;
  assign lid[N]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          pv;
    logic [FW-1:0] pid;
    logic          nv;
    logic [FW-1:0] nid;

    if (i == 0) begin : g_head
      assign pv  = 1'b1;
      assign pid = key;
    end else begin : g_body
      assign pv  = vld_vec[i-1];
      assign pid = id_a[i-1];
    end

    if (i == N-1) begin : g_tail
      assign nv  = 1'b0;
      assign nid = '0;
    end else begin : g_next
      assign nv  = vld_vec[i+1];
      assign nid = id_a[i+1];
    end

    bplru_cell #(
      .FW       (FW),
      .INIT_VLD (INIT_FULL),
      .INIT_ID  (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op           (op),
      .key          (key),
      .prv_vld      (pv),
      .prv_id       (pid),
      .nxt_vld      (nv),
      .nxt_id       (nid),
      .found_in     (found[i]),
      .found_out    (found[i+1]),
      .unpinned     (!pin_pad[id_a[i]]),
      .later_in     (later[i+1]),
      .later_id_in  (lid[i+1]),
      .later_out    (later[i]),
      .later_id_out (lid[i]),
      .vld          (vld_vec[i]),
      .id           (id_a[i])
    );
  end

  assign stat.head_vld     = vld_vec[0];
  assign stat.tail_vld     = vld_vec[N-1];
  assign stat.victim_found = later[0];
  assign head_id           = id_a[0];
  assign victim_id         = lid[0];

endmodule

// ===== hw/rtl/buffer_pool_lru_frame_table.sv =====
// Top level of the buffer pool frame table: controller, frame bits, tags.
// Depends on bplru_pkg, bplru_list (and bplru_cell), assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in      | input     | in_valid/in_stall  | command, file_id, page_number
//   out     | output    | out_valid/out_stall| kind, status, frame, file, page,
//           |           |                    | byte_offset, last
//   cfg     | input     | psel/penable/pready| page_bytes @0x0, header_bytes @0x4
//
// A plain answer takes accept, lookup and respond steps. A write-back adds tag
// read, multiply and emit, a fill multiply and emit, an install its own step and a
// get miss a fill-done step. A flush file scans all frames, adds a release per
// resident frame of the file and a write-back per dirty one; a clear all frees
// resident frames in turn. out_stall holds only the emit step: a new item is
// taken while the last response still waits. Reset is synchronous; tags have none.
module buffer_pool_lru_frame_table
  import bplru_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  localparam int FW        = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [FILE_W-1:0]      in_file_id,
  input  logic [PAGE_W-1:0]      in_page_number,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      out_kind,
  output logic [STAT_W-1:0]      out_status,
  output logic [FW-1:0]          out_frame,
  output logic [FILE_W-1:0]      out_file,
  output logic [PAGE_W-1:0]      out_page,
  output logic [OFF_W-1:0]       out_byte_offset,
  output logic                   out_last,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_WBSET, S_MUL, S_EMIT, S_INSTALL,
    S_FILLDONE, S_RELEASE, S_SCAN, S_CLEAR
  } state_t;

  state_t               state_r;
  state_t               ret_r;
  state_t               post_r;
  cmd_t                 cmd_r;
  logic [FILE_W-1:0]    file_r;
  logic [PAGE_W-1:0]    page_r;
  logic [FW-1:0]        slot_r;
  logic [FW-1:0]        idx_r;
  logic                 from_free_r;

  // pending result item
  kind_t                res_kind_r;
  status_t              res_status_r;
  logic [FW-1:0]        res_frame_r;
  logic [FILE_W-1:0]    res_file_r;
  logic [PAGE_W-1:0]    res_page_r;
  logic [OFF_W-1:0]     prod_r;

  logic [PB_W-1:0]      pb_r;
  logic [HB_W-1:0]      hb_r;

  // per-frame state
  logic [FILE_W-1:0]    tag_file_r [NUM_FRAMES];
  logic [PAGE_W-1:0]    tag_page_r [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] in_use_r;
  logic [NUM_FRAMES-1:0] pinned_r;
  logic [NUM_FRAMES-1:0] dirty_r;

  // output register
  logic                 out_valid_r;
  kind_t                out_kind_r;
  status_t              out_status_r;
  logic [FW-1:0]        out_frame_r;
  logic [FILE_W-1:0]    out_file_r;
  logic [PAGE_W-1:0]    out_page_r;
  logic [OFF_W-1:0]     out_off_r;
  logic                 out_last_r;

  // lookup
  logic [NUM_FRAMES-1:0] pmatch;
  logic [NUM_FRAMES-1:0] fmatch;
  logic                 hit;
  logic [FW-1:0]        hit_idx;

  // list rows
  list_op_t             rec_op;
  list_op_t             free_op;
  logic [FW-1:0]        rec_key;
  logic [FW-1:0]        free_key;
  list_stat_t           rec_stat;
  logic [FW-1:0]        rec_head_id;
  logic [FW-1:0]        free_head_id;
  logic [FW-1:0]        victim_id;
  logic [NUM_FRAMES-1:0] rec_vld;
  logic [NUM_FRAMES-1:0] free_vld;

  logic                 out_free;
  logic                 cfg_wr;

  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_HEADER_BYTES) ? {{(DATA_W-HB_W){1'b0}}, hb_r}
                                                    : {{(DATA_W-PB_W){1'b0}}, pb_r};

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_frame       = out_frame_r;
  assign out_file        = out_file_r;
  assign out_page        = out_page_r;
  assign out_byte_offset = out_off_r;
  assign out_last        = out_last_r;

  // Compare the request tag against every frame; tags are unique among
  // resident frames, so take the lowest match.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      fmatch[i] = in_use_r[i] && (tag_file_r[i] == file_r);
      pmatch[i] = fmatch[i] && (tag_page_r[i] == page_r);
      if (pmatch[i] && !hit) begin
        hit     = 1'b1;
        hit_idx = FW'(i);
      end
    end
  end

  // Drive the list rows from the current step.
  always_comb begin
    rec_op   = LOP_HOLD;
    rec_key  = slot_r;
    free_op  = LOP_HOLD;
    free_key = slot_r;
    case (state_r)
      S_LOOK: begin
        if (hit && ((cmd_r == CMD_GET) ||
                    (((cmd_r == CMD_DIRTY) || (cmd_r == CMD_UNPIN)) &&
                     pinned_r[hit_idx]))) begin
          rec_op  = LOP_MOVE;
          rec_key = hit_idx;
        end
      end
      S_INSTALL: begin
        // move a victim to the head, or push a fresh frame there
        rec_op = LOP_MOVE;
        if (from_free_r) begin
          free_op = LOP_POP;
        end
      end
      S_RELEASE: begin
        rec_op  = LOP_REMOVE;
        free_op = LOP_PUSH;
      end
      S_CLEAR: begin
        if (rec_stat.head_vld) begin
          rec_op   = LOP_POP;
          free_op  = LOP_PUSH;
          free_key = rec_head_id;
        end
      end
      default: ;
    endcase
  end

  bplru_list #(
    .N         (NUM_FRAMES),
    .FW        (FW),
    .INIT_FULL (1'b0)
  ) u_recency (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (rec_op),
    .key       (rec_key),
    .pinned    (pinned_r),
    .stat      (rec_stat),
    .head_id   (rec_head_id),
    .victim_id (victim_id),
    .vld_vec   (rec_vld)
  );

  bplru_list #(
    .N         (NUM_FRAMES),
    .FW        (FW),
    .INIT_FULL (1'b1)
  ) u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (free_op),
    .key       (free_key),
    .pinned    ('0),
    .stat      (),
    .head_id   (free_head_id),
    .victim_id (),
    .vld_vec   (free_vld)
  );

  // Tag store: written when a frame is installed.
  always_ff @(posedge clk) begin
    if (state_r == S_INSTALL) begin
      tag_file_r[slot_r] <= file_r;
      tag_page_r[slot_r] <= page_r;
    end
  end

  // Controller: sequencing, frame bits, pending item and output register.
  always_ff @(posedge clk) begin : p_ctrl
    logic          fin;
    status_t       fin_sts;
    logic [FW-1:0] fin_frm;
    fin     = 1'b0;
    fin_sts = STS_OK;
    fin_frm = '0;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      in_use_r    <= '0;
      pinned_r    <= '0;
      dirty_r     <= '0;
      pb_r        <= PAGE_BYTES_RST;
      hb_r        <= HEADER_BYTES_RST;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_HEADER_BYTES) begin
          hb_r <= pwdata[HB_W-1:0];
        end else begin
          pb_r <= pwdata[PB_W-1:0];
        end
      end

      // drop the result once it is taken, unless a new one is loaded now
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(in_command);
            file_r  <= in_file_id;
            page_r  <= in_page_number;
            state_r <= S_LOOK;
          end
        end

        S_LOOK: begin
          case (cmd_r)
            CMD_GET, CMD_ALLOC: begin
              if (hit) begin
                fin = 1'b1;
                if (cmd_r == CMD_GET) begin
                  fin_frm = hit_idx;
                end else begin
                  fin_sts = STS_RESIDENT;
                end
              end else if (!rec_stat.tail_vld) begin
                slot_r      <= free_head_id;
                from_free_r <= 1'b1;
                state_r     <= S_INSTALL;
              end else if (rec_stat.victim_found) begin
                slot_r      <= victim_id;
                from_free_r <= 1'b0;
                post_r      <= S_INSTALL;
                state_r     <= dirty_r[victim_id] ? S_WBSET : S_INSTALL;
              end else begin
                fin     = 1'b1;
                fin_sts = STS_NO_FREE;
              end
            end
            CMD_DIRTY, CMD_UNPIN: begin
              fin = 1'b1;
              if (!hit) begin
                fin_sts = STS_NOT_RESIDENT;
              end else if (!pinned_r[hit_idx]) begin
                fin_sts = STS_NOT_PINNED;
              end else begin
                fin_frm = hit_idx;
                if (cmd_r == CMD_DIRTY) begin
                  dirty_r[hit_idx] <= 1'b1;
                end else begin
                  pinned_r[hit_idx] <= 1'b0;
                end
              end
            end
            CMD_FLUSH_PAGE: begin
              if (hit) begin
                slot_r  <= hit_idx;
                post_r  <= S_RELEASE;
                state_r <= dirty_r[hit_idx] ? S_WBSET : S_RELEASE;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_FLUSH_FILE: begin
              idx_r   <= '0;
              state_r <= S_SCAN;
            end
            CMD_CLEAR: begin
              state_r <= S_CLEAR;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end

        S_WBSET: begin
          // read the old tag and mark the frame clean
          res_kind_r     <= KIND_WB;
          res_status_r   <= STS_OK;
          res_frame_r    <= slot_r;
          res_file_r     <= tag_file_r[slot_r];
          res_page_r     <= tag_page_r[slot_r];
          dirty_r[slot_r] <= 1'b0;
          ret_r          <= post_r;
          state_r        <= S_MUL;
        end

        S_MUL: begin
          prod_r  <= OFF_W'(res_page_r) * OFF_W'(pb_r);
          state_r <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= res_kind_r;
            out_status_r <= res_status_r;
            out_frame_r  <= res_frame_r;
            out_file_r   <= res_file_r;
            out_page_r   <= res_page_r;
            out_off_r    <= (res_kind_r == KIND_FINAL) ? '0 : prod_r + OFF_W'(hb_r);
            out_last_r   <= (res_kind_r == KIND_FINAL);
            state_r      <= ret_r;
          end
        end

        S_INSTALL: begin
          in_use_r[slot_r] <= 1'b1;
          pinned_r[slot_r] <= 1'b1;
          dirty_r[slot_r]  <= 1'b0;
          if (cmd_r == CMD_GET) begin
            res_kind_r   <= KIND_FILL;
            res_status_r <= STS_OK;
            res_frame_r  <= slot_r;
            res_file_r   <= file_r;
            res_page_r   <= page_r;
            ret_r        <= S_FILLDONE;
            state_r      <= S_MUL;
          end else begin
            fin     = 1'b1;
            fin_frm = slot_r;
          end
        end

        S_FILLDONE: begin
          fin     = 1'b1;
          fin_frm = slot_r;
        end

        S_RELEASE: begin
          in_use_r[slot_r] <= 1'b0;
          if (cmd_r == CMD_FLUSH_FILE) begin
            if (idx_r == FW'(NUM_FRAMES - 1)) begin
              fin = 1'b1;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_SCAN;
            end
          end else begin
            fin     = 1'b1;
            fin_frm = slot_r;
          end
        end

        S_SCAN: begin
          if (fmatch[idx_r]) begin
            slot_r  <= idx_r;
            post_r  <= S_RELEASE;
            state_r <= dirty_r[idx_r] ? S_WBSET : S_RELEASE;
          end else if (idx_r == FW'(NUM_FRAMES - 1)) begin
            fin = 1'b1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        S_CLEAR: begin
          // release the most recent frame each cycle until the list drains
          if (rec_stat.head_vld) begin
            in_use_r[rec_head_id] <= 1'b0;
          end else begin
            fin = 1'b1;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      if (fin) begin
        res_kind_r   <= KIND_FINAL;
        res_status_r <= fin_sts;
        res_frame_r  <= fin_frm;
        res_file_r   <= '0;
        res_page_r   <= '0;
        ret_r        <= S_IDLE;
        state_r      <= S_EMIT;
      end
    end
  end

  // Every frame sits in exactly one of the two lists.
  `BP_ASSERT(a_lists_cover, ($countones(rec_vld) + $countones(free_vld)) == NUM_FRAMES, "frame lost or doubled between lists")
  // Resident bits track the recency list.
  `BP_ASSERT(a_use_matches_list, $countones(in_use_r) == $countones(rec_vld), "resident bits disagree with recency list")
  // Only the final response of a request carries last.
  `BP_ASSERT_IMPL(a_last_on_final, out_valid_r, out_last_r == (out_kind_r == KIND_FINAL), "last flag on wrong item kind")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for buffer_pool_lru_frame_table: requests go in on the
// request channel and every result item is checked against a frame-table predictor.
// Depends on bplru_pkg and the RTL of the block; reads no files.
module tb_top;
  import bplru_pkg::*;

  localparam int NF = 16;
  localparam int WATCH_LIMIT = 4000;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] file;
    logic [23:0] page;
  } req_t;

  typedef struct {
    kind_t       kind;
    status_t     status;
    logic [3:0]  frame;
    logic [15:0] file;
    logic [23:0] page;
    logic [40:0] offset;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_command = '0;
  logic [FILE_W-1:0] in_file_id = '0;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [STAT_W-1:0] out_status;
  logic [3:0] out_frame;
  logic [FILE_W-1:0] out_file;
  logic [PAGE_W-1:0] out_page;
  logic [OFF_W-1:0] out_byte_offset;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  buffer_pool_lru_frame_table #(.NUM_FRAMES(NF)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores.
  req_t    pending_reqs[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      reqs_taken = 0;
  logic    quiet = 1'b0;

  // Predictor state: tags, frame bits, recency list (MRU first), free list.
  logic [16:0] pg_bytes = 17'd4096;
  logic [15:0] hdr_bytes = 16'd0;
  logic [15:0] tag_f[NF];
  logic [23:0] tag_p[NF];
  logic        resident[NF];
  logic        pinned[NF];
  logic        dirty[NF];
  int          mru[NF];
  int          free_q[NF];
  int          n_used;

  initial begin
    for (int i = 0; i < NF; i++) begin
      tag_f[i] = '0; tag_p[i] = '0; resident[i] = 0; pinned[i] = 0; dirty[i] = 0;
      mru[i] = 0; free_q[i] = i;
    end
    n_used = 0;
  end

  function automatic logic [40:0] page_offset(logic [23:0] p);
    return 41'(p) * 41'(pg_bytes) + 41'(hdr_bytes);
  endfunction

  function automatic void emit_result(kind_t k, status_t s, int f, logic [15:0] fl,
                                      logic [23:0] pg, logic [40:0] off, logic lst);
    result_t r;
    r.kind = k; r.status = s; r.frame = 4'(f); r.file = fl; r.page = pg;
    r.offset = off; r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void drop_mru_at(int pos);
    if (pos >= n_used) return;
    for (int k = pos; k < n_used - 1; k++) mru[k] = mru[k+1];
    n_used--;
  endfunction

  function automatic void drop_mru(int f);
    for (int k = 0; k < n_used; k++)
      if (mru[k] == f) begin
        drop_mru_at(k);
        return;
      end
  endfunction

  function automatic void push_mru(int f);
    if (n_used >= NF) return;
    for (int k = n_used; k > 0; k--) mru[k] = mru[k-1];
    mru[0] = f;
    n_used++;
  endfunction

  function automatic void write_back(int f);
    emit_result(KIND_WB, STS_OK, f, tag_f[f], tag_p[f], page_offset(tag_p[f]), 0);
    dirty[f] = 0;
  endfunction

  // Move a resident frame to the head of the free list.
  function automatic void free_frame(int f);
    int fc;
    fc = NF - n_used;
    if (n_used == 0) return;
    for (int k = fc; k > 0; k--) free_q[k] = free_q[k-1];
    free_q[0] = f;
    resident[f] = 0;
    drop_mru(f);
  endfunction

  // Take the free head, else evict the least recent unpinned frame.
  function automatic int claim_frame();
    int f;
    if (n_used < NF) begin
      f = free_q[0];
      for (int k = 0; k < NF - n_used - 1; k++) free_q[k] = free_q[k+1];
      push_mru(f);
      return f;
    end
    for (int k = n_used; k > 0; k--) begin
      f = mru[k-1];
      if (!pinned[f]) begin
        if (dirty[f]) write_back(f);
        resident[f] = 0;
        drop_mru_at(k - 1);
        push_mru(f);
        return f;
      end
    end
    return -1;
  endfunction

  function automatic void frame_table_predict(req_t r);
    int hit;
    int f;
    hit = -1;
    for (int i = NF - 1; i >= 0; i--)
      if (resident[i] && tag_f[i] == r.file && tag_p[i] == r.page) hit = i;
    case (r.cmd)
      CMD_GET, CMD_ALLOC: begin
        if (hit >= 0) begin
          if (r.cmd == CMD_GET) begin
            drop_mru(hit); push_mru(hit);
            emit_result(KIND_FINAL, STS_OK, hit, 0, 0, 0, 1);
          end else begin
            emit_result(KIND_FINAL, STS_RESIDENT, 0, 0, 0, 0, 1);
          end
        end else begin
          f = claim_frame();
          if (f < 0) begin
            emit_result(KIND_FINAL, STS_NO_FREE, 0, 0, 0, 0, 1);
          end else begin
            if (r.cmd == CMD_GET)
              emit_result(KIND_FILL, STS_OK, f, r.file, r.page, page_offset(r.page), 0);
            tag_f[f] = r.file; tag_p[f] = r.page;
            resident[f] = 1; dirty[f] = 0; pinned[f] = 1;
            emit_result(KIND_FINAL, STS_OK, f, 0, 0, 0, 1);
          end
        end
      end
      CMD_DIRTY, CMD_UNPIN: begin
        if (hit < 0) begin
          emit_result(KIND_FINAL, STS_NOT_RESIDENT, 0, 0, 0, 0, 1);
        end else if (!pinned[hit]) begin
          emit_result(KIND_FINAL, STS_NOT_PINNED, 0, 0, 0, 0, 1);
        end else begin
          if (r.cmd == CMD_DIRTY) dirty[hit] = 1;
          else pinned[hit] = 0;
          drop_mru(hit); push_mru(hit);
          emit_result(KIND_FINAL, STS_OK, hit, 0, 0, 0, 1);
        end
      end
      CMD_FLUSH_PAGE: begin
        if (hit >= 0) begin
          if (dirty[hit]) write_back(hit);
          free_frame(hit);
          emit_result(KIND_FINAL, STS_OK, hit, 0, 0, 0, 1);
        end else begin
          emit_result(KIND_FINAL, STS_OK, 0, 0, 0, 0, 1);
        end
      end
      CMD_FLUSH_FILE: begin
        for (int i = 0; i < NF; i++) begin
          if (resident[i] && tag_f[i] == r.file) begin
            if (dirty[i]) write_back(i);
            free_frame(i);
          end
        end
        emit_result(KIND_FINAL, STS_OK, 0, 0, 0, 0, 1);
      end
      CMD_CLEAR: begin
        while (n_used > 0) free_frame(mru[0]);
        emit_result(KIND_FINAL, STS_OK, 0, 0, 0, 0, 1);
      end
      default: emit_result(KIND_FINAL, STS_OK, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // Driver: present the next pending item, hold it while stalled, idle in bursts.
  req_t cur_req;
  int   send_gap = 0;
  logic presenting;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      presenting = in_valid;
      if (in_valid && !in_stall) begin
        frame_table_predict(cur_req);
        reqs_taken++;
        presenting = 1'b0;
      end
      if (!presenting) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 12);
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs[0];
          pending_reqs.delete(0);
          presenting = 1'b1;
          in_command <= cur_req.cmd;
          in_file_id <= cur_req.file;
          in_page_number <= cur_req.page;
        end
        in_valid <= presenting;
      end
    end
  end

  // Monitor and receiver: check each result item, stall in bursts, and once
  // hold off long enough for the block to back up onto its input.
  int      rx_gap = 0;
  int      long_hold = 0;
  logic    long_hold_done = 1'b0;
  logic    stall_next;
  result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing expected: kind %0d frame %0d", out_kind, out_frame);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_kind !== want.kind || out_status !== want.status ||
              out_frame !== want.frame || out_file !== want.file ||
              out_page !== want.page || out_byte_offset !== want.offset ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp k%0d s%0d f%0d %0h/%0h off %0h l%0d, got k%0d s%0d f%0d %0h/%0h off %0h l%0d",
                       want.kind, want.status, want.frame, want.file, want.page,
                       want.offset, want.last, out_kind, out_status, out_frame,
                       out_file, out_page, out_byte_offset, out_last);
          end
        end
      end
      if (!long_hold_done && reqs_taken >= 150) begin
        long_hold = 300;
        long_hold_done = 1'b1;
      end
      if (long_hold > 0) begin
        long_hold--;
        stall_next = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        stall_next = 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(0, 12);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; the predictor follows.
  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'h0) pg_bytes = data[16:0];
    else hdr_bytes = data[15:0];
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic void add_req(cmd_t c, logic [15:0] f, logic [23:0] p);
    req_t r;
    r.cmd = c; r.file = f; r.page = p;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Mostly tags from a small pool so hits, evictions and write-backs happen;
  // some fully random tags for bit coverage.
  function automatic void add_random_req();
    int sel;
    cmd_t c;
    logic [15:0] f;
    logic [23:0] p;
    sel = $urandom_range(0, 99);
    if (sel < 30) c = CMD_GET;
    else if (sel < 40) c = CMD_ALLOC;
    else if (sel < 55) c = CMD_DIRTY;
    else if (sel < 80) c = CMD_UNPIN;
    else if (sel < 89) c = CMD_FLUSH_PAGE;
    else if (sel < 95) c = CMD_FLUSH_FILE;
    else if (sel < 98) c = CMD_CLEAR;
    else c = CMD_NOP;
    if ($urandom_range(0, 9) == 0) begin
      f = 16'($urandom);
      p = 24'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: f = 16'h0000;
        1: f = 16'h0001;
        2: f = 16'h8a5c;
        default: f = 16'hffff;
      endcase
      p = ($urandom_range(0, 7) == 7) ? 24'hffffff : 24'($urandom_range(0, 6));
    end
    add_req(c, f, p);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset configuration.
    @(negedge clk);
    add_req(CMD_GET, 16'h0000, 24'h000000);
    add_req(CMD_GET, 16'hffff, 24'hffffff);
    add_req(CMD_ALLOC, 16'h0000, 24'h000000);        // already resident
    add_req(CMD_ALLOC, 16'h0001, 24'h000005);
    add_req(CMD_DIRTY, 16'h0000, 24'h000000);
    add_req(CMD_DIRTY, 16'h0009, 24'h000009);        // not resident
    add_req(CMD_UNPIN, 16'h0000, 24'h000000);
    add_req(CMD_UNPIN, 16'h0000, 24'h000000);        // not pinned
    add_req(CMD_GET, 16'h0000, 24'h000000);          // hit, no re-pin
    add_req(CMD_FLUSH_PAGE, 16'h0000, 24'h000000);   // dirty page written back
    add_req(CMD_FLUSH_PAGE, 16'h0007, 24'h000007);   // not resident, still ok
    add_req(CMD_NOP, 16'h1234, 24'h567890);
    for (int i = 0; i < 14; i++)
      add_req((i % 2) ? CMD_ALLOC : CMD_GET, 16'h0002, 24'(i));
    add_req(CMD_GET, 16'h0003, 24'h000003);          // every frame pinned
    add_req(CMD_DIRTY, 16'h0002, 24'h000000);
    add_req(CMD_FLUSH_FILE, 16'h0002, 24'h000000);
    add_req(CMD_CLEAR, 16'h0000, 24'h000000);
    drain();

    // Random phases, each under its own configuration; the sender pauses
    // for a full drain before every register write.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin reg_write(3'h0, 32'd1); reg_write(3'h4, 32'd0); end
        1: begin reg_write(3'h0, 32'd65536); reg_write(3'h4, 32'd65535); end
        2: begin
          reg_write(3'h0, 32'($urandom_range(1, 65536)));
          reg_write(3'h4, 32'($urandom_range(0, 65535)));
        end
        default: begin reg_write(3'h0, 32'd4096); reg_write(3'h4, 32'd100); end
      endcase
      @(negedge clk);
      if (ph == 3) quiet = 1'b1;
      for (int i = 0; i < 88; i++) add_random_req();
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
